/* hdl/status_led_pattern_driver_macros.svh */
// Assertion macros for the status LED pattern driver.
// Expects signals clk and rst_n in the scope of each use.
`ifndef STATUS_LED_PATTERN_DRIVER_MACROS_SVH
`define STATUS_LED_PATTERN_DRIVER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SLED_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("status LED driver: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define SLED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("status LED driver: next-cycle check failed");

`endif

/* hdl/sled_pkg.sv */
// Shared types and constants for the status LED pattern driver.
// No dependencies; used by the interfaces, sled_pattern and the top level.
package sled_pkg;

  localparam int ACTION_W = 2;
  localparam int MODE_W   = 2;
  localparam int HOLD_W   = 8;
  localparam int CNT_W    = HOLD_W + 1;
  localparam int SLOW_W   = 10;
  localparam int FAST_W   = 7;
  localparam int SEARCH_W = 11;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK     = 2'd0,
    ACT_POWER    = 2'd1,
    ACT_CONN     = 2'd2,
    ACT_ACTIVITY = 2'd3
  } action_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF    = 2'd0,
    MODE_ON     = 2'd1,
    MODE_BLINK  = 2'd2,
    MODE_SEARCH = 2'd3
  } mode_t;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd200;

  localparam logic [SLOW_W-1:0]   SLOW_LAST   = 10'd999;
  localparam logic [SLOW_W-1:0]   SLOW_LIT    = 10'd500;
  localparam logic [FAST_W-1:0]   FAST_LAST   = 7'd99;
  localparam logic [FAST_W-1:0]   FAST_LIT    = 7'd50;
  localparam logic [SEARCH_W-1:0] SEARCH_LAST = 11'd1399;

  localparam logic [SEARCH_W-1:0] PWR_A_END  = 11'd300;
  localparam logic [SEARCH_W-1:0] PWR_B_BEG  = 11'd900;
  localparam logic [SEARCH_W-1:0] PWR_B_END  = 11'd1200;
  localparam logic [SEARCH_W-1:0] CONN_A_BEG = 11'd100;
  localparam logic [SEARCH_W-1:0] CONN_A_END = 11'd400;
  localparam logic [SEARCH_W-1:0] CONN_B_BEG = 11'd800;
  localparam logic [SEARCH_W-1:0] CONN_B_END = 11'd1100;
  localparam logic [SEARCH_W-1:0] ACT_A_BEG  = 11'd200;
  localparam logic [SEARCH_W-1:0] ACT_A_END  = 11'd500;
  localparam logic [SEARCH_W-1:0] ACT_B_BEG  = 11'd700;
  localparam logic [SEARCH_W-1:0] ACT_B_END  = 11'd1000;

  typedef struct packed {
    mode_t               power_mode;
    mode_t               conn_mode;
    mode_t               act_mode;
    logic [SLOW_W-1:0]   slow_phase;
    logic [FAST_W-1:0]   fast_phase;
    logic [SEARCH_W-1:0] search_phase;
  } led_view_t;

  typedef struct packed {
    logic power;
    logic conn;
    logic act;
  } led_bits_t;

endpackage

/* hdl/sled_if.sv */
// Valid/ready channel interfaces for the status LED pattern driver.
// Depends on sled_pkg for field widths.
interface sled_in_if;
  logic                          valid;
  logic                          ready;
  logic [sled_pkg::ACTION_W-1:0] action;
  logic [sled_pkg::MODE_W-1:0]   mode_value;
  logic                          force_now;

  modport source (output valid, action, mode_value, force_now, input ready);
  modport sink (input valid, action, mode_value, force_now, output ready);
endinterface

interface sled_out_if;
  logic                        valid;
  logic                        ready;
  logic                        power_led;
  logic                        connection_led;
  logic                        activity_led;
  logic [sled_pkg::MODE_W-1:0] power_mode_now;
  logic [sled_pkg::MODE_W-1:0] connection_mode_now;
  logic [sled_pkg::MODE_W-1:0] activity_mode_now;

  modport source (output valid, power_led, connection_led, activity_led,
                  power_mode_now, connection_mode_now, activity_mode_now,
                  input ready);
  modport sink (input valid, power_led, connection_led, activity_led,
                power_mode_now, connection_mode_now, activity_mode_now,
                output ready);
endinterface

/* hdl/status_led_pattern_driver.sv */
// Status LED pattern driver: three LEDs driven from millisecond ticks and mode writes.
// Usage: in_ch carries items (action, mode_value, force_now); out_ch returns one item
// per input item with the three LED levels and the current power, connection and
// activity modes. cfg_we/cfg_data write the activity-off hold in ticks (reset 200).
// The result is registered: an item accepted at an edge has its result valid after that edge.
// Throughput is one item per clock while out_ch.ready is high; all state updates and
// LED decode happen in the accept cycle, and a single output register holds the result.
// If the receiver stalls, the result stays registered and in_ch.ready follows
// out_ch.ready, so a new item is taken in the same cycle the held one leaves.
// Synchronous active-low reset clears all modes to off, all phases and the
// pending-off counter to zero, empties the output register and holds in_ch.ready low.
// Depends on sled_pkg, sled_if, sled_pattern and the macro header.
`include "status_led_pattern_driver_macros.svh"

module status_led_pattern_driver (
  input  logic                        clk,
  input  logic                        rst_n,
  sled_in_if.sink                     in_ch,
  sled_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [sled_pkg::HOLD_W-1:0] cfg_data
);

  logic [sled_pkg::HOLD_W-1:0]   hold_r;
  logic [sled_pkg::SLOW_W-1:0]   slow_r, slow_nxt;
  logic [sled_pkg::FAST_W-1:0]   fast_r, fast_nxt;
  logic [sled_pkg::SEARCH_W-1:0] search_r, search_nxt;
  sled_pkg::mode_t               pwr_r, pwr_nxt;
  sled_pkg::mode_t               conn_r, conn_nxt;
  sled_pkg::mode_t               act_r, act_nxt;
  logic [sled_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;

  logic                out_valid_r;
  sled_pkg::led_bits_t leds_r;
  sled_pkg::led_bits_t leds_nxt;
  sled_pkg::mode_t     pwr_out_r, conn_out_r, act_out_r;
  sled_pkg::led_view_t view;

  logic            in_fire;
  logic            force_off;
  sled_pkg::mode_t in_mode;

  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_mode     = sled_pkg::mode_t'(in_ch.mode_value);
  assign force_off   = in_fire && in_ch.action == sled_pkg::ACT_ACTIVITY &&
                       in_ch.mode_value == sled_pkg::MODE_OFF && in_ch.force_now;

  always_comb begin
    slow_nxt   = slow_r;
    fast_nxt   = fast_r;
    search_nxt = search_r;
    pwr_nxt    = pwr_r;
    conn_nxt   = conn_r;
    act_nxt    = act_r;
    cnt_nxt    = cnt_r;
    if (in_fire) begin
      unique case (sled_pkg::action_t'(in_ch.action))
        sled_pkg::ACT_TICK: begin
          slow_nxt   = (slow_r == sled_pkg::SLOW_LAST) ? '0 : slow_r + 1'b1;
          fast_nxt   = (fast_r == sled_pkg::FAST_LAST) ? '0 : fast_r + 1'b1;
          search_nxt = (search_r == sled_pkg::SEARCH_LAST) ? '0 : search_r + 1'b1;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - 1'b1;
            if (cnt_r == sled_pkg::CNT_W'(1)) begin
              act_nxt = sled_pkg::MODE_OFF;
            end
          end
        end
        sled_pkg::ACT_POWER: begin
          if (in_mode != sled_pkg::MODE_SEARCH) begin
            pwr_nxt = in_mode;
          end
        end
        sled_pkg::ACT_CONN: begin
          if (conn_r != sled_pkg::MODE_SEARCH && in_mode == sled_pkg::MODE_SEARCH) begin
            search_nxt = '0;
          end
          conn_nxt = in_mode;
        end
        sled_pkg::ACT_ACTIVITY: begin
          unique case (in_mode)
            sled_pkg::MODE_OFF: begin
              if (in_ch.force_now) begin
                act_nxt = sled_pkg::MODE_OFF;
                cnt_nxt = '0;
              end else begin
                cnt_nxt = {1'b0, hold_r} + sled_pkg::CNT_W'(1);
              end
            end
            sled_pkg::MODE_ON: begin
              act_nxt = sled_pkg::MODE_ON;
            end
            sled_pkg::MODE_BLINK: begin
              act_nxt = sled_pkg::MODE_BLINK;
              cnt_nxt = '0;
            end
            sled_pkg::MODE_SEARCH: begin
            end
          endcase
        end
      endcase
    end
  end

  always_comb begin
    view.power_mode   = pwr_nxt;
    view.conn_mode    = conn_nxt;
    view.act_mode     = act_nxt;
    view.slow_phase   = slow_nxt;
    view.fast_phase   = fast_nxt;
    view.search_phase = search_nxt;
  end

  sled_pattern u_pattern (
    .view (view),
    .leds (leds_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r      <= sled_pkg::HOLD_RESET;
      slow_r      <= '0;
      fast_r      <= '0;
      search_r    <= '0;
      pwr_r       <= sled_pkg::MODE_OFF;
      conn_r      <= sled_pkg::MODE_OFF;
      act_r       <= sled_pkg::MODE_OFF;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        hold_r <= cfg_data;
      end
      slow_r   <= slow_nxt;
      fast_r   <= fast_nxt;
      search_r <= search_nxt;
      pwr_r    <= pwr_nxt;
      conn_r   <= conn_nxt;
      act_r    <= act_nxt;
      cnt_r    <= cnt_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      leds_r     <= leds_nxt;
      pwr_out_r  <= pwr_nxt;
      conn_out_r <= conn_nxt;
      act_out_r  <= act_nxt;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.power_led           = leds_r.power;
  assign out_ch.connection_led      = leds_r.conn;
  assign out_ch.activity_led        = leds_r.act;
  assign out_ch.power_mode_now      = pwr_out_r;
  assign out_ch.connection_mode_now = conn_out_r;
  assign out_ch.activity_mode_now   = act_out_r;

  `SLED_ASSERT_NEXT(a_fire_gives_result, in_fire, out_valid_r)
  `SLED_ASSERT_SAME(a_power_never_search, 1'b1, pwr_r != sled_pkg::MODE_SEARCH)
  `SLED_ASSERT_SAME(a_slow_in_range, 1'b1, slow_r <= sled_pkg::SLOW_LAST)
  `SLED_ASSERT_NEXT(a_forced_off, force_off, act_r == sled_pkg::MODE_OFF && cnt_r == '0)

endmodule

/* hdl/sled_pattern.sv */
// LED level decode from modes and phase counters: search chase or per-LED mode.
// Depends on sled_pkg.
module sled_pattern (
  input  sled_pkg::led_view_t view,
  output sled_pkg::led_bits_t leds
);

  logic chase_pwr;
  logic chase_conn;
  logic chase_act;
  logic slow_on;
  logic fast_on;

  always_comb begin
    chase_pwr  = (view.search_phase < sled_pkg::PWR_A_END) ||
                 (view.search_phase >= sled_pkg::PWR_B_BEG &&
                  view.search_phase < sled_pkg::PWR_B_END);
    chase_conn = (view.search_phase >= sled_pkg::CONN_A_BEG &&
                  view.search_phase < sled_pkg::CONN_A_END) ||
                 (view.search_phase >= sled_pkg::CONN_B_BEG &&
                  view.search_phase < sled_pkg::CONN_B_END);
    chase_act  = (view.search_phase >= sled_pkg::ACT_A_BEG &&
                  view.search_phase < sled_pkg::ACT_A_END) ||
                 (view.search_phase >= sled_pkg::ACT_B_BEG &&
                  view.search_phase < sled_pkg::ACT_B_END);
    slow_on = view.slow_phase < sled_pkg::SLOW_LIT;
    fast_on = view.fast_phase < sled_pkg::FAST_LIT;

    if (view.conn_mode == sled_pkg::MODE_SEARCH) begin
      leds.power = chase_pwr;
      leds.conn  = chase_conn;
      leds.act   = chase_act;
    end else begin
      leds.power = (view.power_mode == sled_pkg::MODE_ON) ||
                   (view.power_mode == sled_pkg::MODE_BLINK && slow_on);
      leds.conn  = (view.conn_mode == sled_pkg::MODE_ON) ||
                   (view.conn_mode == sled_pkg::MODE_BLINK && slow_on);
      leds.act   = (view.act_mode == sled_pkg::MODE_BLINK) && fast_on;
    end
  end

endmodule
